// File: rtl/polar_stencil_entry_offset_top_assert.svh
// Assertion macros for the polar stencil entry offset block.
`ifndef POLAR_STENCIL_ENTRY_OFFSET_TOP_ASSERT_SVH
`define POLAR_STENCIL_ENTRY_OFFSET_TOP_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define PSEO_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Delayed implication, checked on every rising edge outside reset.
`define PSEO_ASSERT_DLY3(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##3 (cons)) \
    else $error(msg);

`endif

// File: rtl/pseo_pkg.sv
// Shared types and constants for the polar stencil entry offset block.
`default_nettype none

package pseo_pkg;

  // Default clamp limits for the grid counts.
  localparam int RADIAL_MAX_DEFAULT  = 4096;
  localparam int ANGULAR_MAX_DEFAULT = 4096;

  // Field widths.
  localparam int IDX_W    = 12;
  localparam int COUNT_W  = 13;
  localparam int REGION_W = 12;
  localparam int OFF_W    = 28;
  localparam int KIND_W   = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;

  // Product widths of the first stage.
  localparam int PCIRC_W = IDX_W + COUNT_W;
  localparam int PCN_W   = REGION_W + COUNT_W;
  localparam int PLR_W   = COUNT_W + REGION_W;
  localparam int PNR_W   = COUNT_W + COUNT_W;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_RADIAL_COUNT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ANGULAR_COUNT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CIRCLE_REGION  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIAL_REGION  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DIRICHLET      = 3'd4;

  // Stencil class codes.
  localparam logic [KIND_W-1:0] KIND_INTERIOR   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_ACROSS     = 3'd1;
  localparam logic [KIND_W-1:0] KIND_DIRICHLET  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_NEXT_INNER = 3'd3;
  localparam logic [KIND_W-1:0] KIND_NEXT_OUTER = 3'd4;

  // Which offset formula a row uses.
  typedef enum logic [2:0] {
    REGION_CIRCLE,
    REGION_RADIAL,
    REGION_ZERO,
    REGION_ONE,
    REGION_NEXT_OUTER,
    REGION_OUTER
  } region_t;

  typedef struct packed {
    logic [IDX_W-1:0] radial_index;
    logic [IDX_W-1:0] angular_index;
  } req_t;

  typedef struct packed {
    logic [OFF_W-1:0]  entry_offset;
    logic [KIND_W-1:0] stencil_kind;
    logic [OFF_W-1:0]  total_nonzeros;
    logic              index_valid;
  } rsp_t;

  typedef struct packed {
    logic [COUNT_W-1:0]  radial_count;
    logic [COUNT_W-1:0]  angular_count;
    logic [REGION_W-1:0] circle_region_count;
    logic [REGION_W-1:0] radial_region_length;
    logic                dirichlet_inner;
  } cfg_t;

  // First stage: classification and raw products.
  typedef struct packed {
    logic                valid;
    logic                idx_valid;
    logic [KIND_W-1:0]   kind;
    region_t             region;
    logic                dir;
    logic [IDX_W-1:0]    ir;
    logic [IDX_W-1:0]    it;
    logic [COUNT_W-1:0]  nt;
    logic [REGION_W-1:0] nc;
    logic [REGION_W-1:0] lr;
    logic [PCIRC_W-1:0]  p_circ;
    logic [PCN_W-1:0]    p_cn;
    logic [PLR_W-1:0]    p_lr;
    logic [PNR_W-1:0]    p_nr;
  } s1_t;

  // Second stage: each result is nine times one term plus another.
  typedef struct packed {
    logic              valid;
    logic              idx_valid;
    logic [KIND_W-1:0] kind;
    logic [OFF_W-1:0]  s_off;
    logic [OFF_W-1:0]  e_off;
    logic [OFF_W-1:0]  s_tot;
    logic [OFF_W-1:0]  e_tot;
  } s2_t;

endpackage

`default_nettype wire

// File: rtl/pseo_prod.sv
// First pipeline stage: count clamping, row classification and products.
`default_nettype none

module pseo_prod #(
  parameter int RADIAL_MAX  = pseo_pkg::RADIAL_MAX_DEFAULT,
  parameter int ANGULAR_MAX = pseo_pkg::ANGULAR_MAX_DEFAULT
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  pseo_pkg::req_t req,
  input  pseo_pkg::cfg_t cfg,
  output pseo_pkg::s1_t  s1
);

  pseo_pkg::s1_t                 s1_next;
  logic [pseo_pkg::COUNT_W-1:0]  nr;
  logic [pseo_pkg::COUNT_W-1:0]  nt;
  logic [pseo_pkg::COUNT_W-1:0]  nr_m1;
  logic [pseo_pkg::COUNT_W-1:0]  nr_m2;
  logic [pseo_pkg::COUNT_W-1:0]  ir_ext;
  logic [pseo_pkg::COUNT_W-1:0]  it_ext;
  logic [pseo_pkg::COUNT_W-1:0]  nc_ext;
  logic [pseo_pkg::COUNT_W-1:0]  it_p1;
  logic [pseo_pkg::IDX_W-1:0]    ir_m2;
  logic                          in_grid;
  logic                          dir;

  // Clamp the counts, then classify the requested row.
  always_comb begin
    nr = (int'({19'd0, cfg.radial_count}) > RADIAL_MAX) ?
         pseo_pkg::COUNT_W'(RADIAL_MAX) : cfg.radial_count;
    nt = (int'({19'd0, cfg.angular_count}) > ANGULAR_MAX) ?
         pseo_pkg::COUNT_W'(ANGULAR_MAX) : cfg.angular_count;
    nr_m1  = nr - 13'd1;
    nr_m2  = nr - 13'd2;
    ir_ext = {1'b0, req.radial_index};
    it_ext = {1'b0, req.angular_index};
    nc_ext = {1'b0, cfg.circle_region_count};
    it_p1  = it_ext + 13'd1;
    ir_m2  = req.radial_index - 12'd2;
    dir    = cfg.dirichlet_inner;
    in_grid = (nr >= 13'd4) && (ir_ext < nr) && (it_ext < nt);

    // The valid bit is cleared while reset is held.
    s1_next.valid     = in_valid && !rst;
    s1_next.idx_valid = in_grid;
    s1_next.dir       = dir;
    s1_next.ir        = req.radial_index;
    s1_next.it        = req.angular_index;
    s1_next.nt        = nt;
    s1_next.nc        = cfg.circle_region_count;
    s1_next.lr        = cfg.radial_region_length;

    // Offset formula, in priority order.
    if (ir_ext > 13'd1 && ir_ext < nc_ext) begin
      s1_next.region = pseo_pkg::REGION_CIRCLE;
    end else if (ir_ext >= nc_ext && ir_ext < nr_m2) begin
      s1_next.region = pseo_pkg::REGION_RADIAL;
    end else if (ir_ext == 13'd0) begin
      s1_next.region = pseo_pkg::REGION_ZERO;
    end else if (ir_ext == 13'd1) begin
      s1_next.region = pseo_pkg::REGION_ONE;
    end else if (ir_ext == nr_m2) begin
      s1_next.region = pseo_pkg::REGION_NEXT_OUTER;
    end else begin
      s1_next.region = pseo_pkg::REGION_OUTER;
    end

    // Stencil class; an index outside the grid reports interior.
    if (!in_grid) begin
      s1_next.kind = pseo_pkg::KIND_INTERIOR;
    end else if ((ir_ext > 13'd1 && ir_ext < nr_m2) || (ir_ext == 13'd1 && !dir)) begin
      s1_next.kind = pseo_pkg::KIND_INTERIOR;
    end else if (ir_ext == 13'd0 && !dir) begin
      s1_next.kind = pseo_pkg::KIND_ACROSS;
    end else if ((ir_ext == 13'd0 && dir) || ir_ext == nr_m1) begin
      s1_next.kind = pseo_pkg::KIND_DIRICHLET;
    end else if (ir_ext == 13'd1 && dir) begin
      s1_next.kind = pseo_pkg::KIND_NEXT_INNER;
    end else begin
      s1_next.kind = pseo_pkg::KIND_NEXT_OUTER;
    end

    // Four narrow products side by side.
    s1_next.p_circ = {13'd0, ir_m2} * {12'd0, nt};
    s1_next.p_cn   = {13'd0, cfg.circle_region_count} * {12'd0, nt};
    s1_next.p_lr   = {12'd0, it_p1} * {13'd0, cfg.radial_region_length};
    s1_next.p_nr   = {13'd0, nr} * {13'd0, nt};
  end

  // Stage register; the valid bit is cleared through its next value.
  always_ff @(posedge clk) begin
    s1 <= s1_next;
  end

endmodule

`default_nettype wire

// File: rtl/pseo_sum.sv
// Second pipeline stage: sums that build the terms of each result.
`default_nettype none

module pseo_sum (
  input  logic          clk,
  input  logic          rst,
  input  pseo_pkg::s1_t s1,
  output pseo_pkg::s2_t s2
);

  pseo_pkg::s2_t               s2_next;
  logic [pseo_pkg::OFF_W-1:0]  nt_w;
  logic [pseo_pkg::OFF_W-1:0]  it_w;
  logic [pseo_pkg::OFF_W-1:0]  ir_w;
  logic [pseo_pkg::OFF_W-1:0]  nc_w;
  logic [pseo_pkg::OFF_W-1:0]  lr_m2;
  logic [pseo_pkg::OFF_W-1:0]  base;
  logic [pseo_pkg::OFF_W-1:0]  seven_it;
  logic [pseo_pkg::OFF_W-1:0]  seven_nt;
  logic [pseo_pkg::OFF_W-1:0]  cn;
  logic [pseo_pkg::OFF_W-1:0]  q;
  logic [pseo_pkg::OFF_W-1:0]  tail;

  // All sums wrap at the width of the result fields.
  always_comb begin
    nt_w     = 28'(s1.nt);
    it_w     = 28'(s1.it);
    ir_w     = 28'(s1.ir);
    nc_w     = 28'(s1.nc);
    lr_m2    = 28'(s1.lr) - 28'd2;
    seven_it = (it_w << 3) - it_w;
    seven_nt = (nt_w << 3) - nt_w;
    // Rows ahead of the interior: (1 + 6) or (7 + 9) entries per angle.
    base     = s1.dir ? seven_nt : (nt_w << 4);
    // Circle section size and the radial rows of earlier angles.
    cn       = 28'(s1.p_cn) - (nt_w << 1);
    q        = 28'(s1.p_lr) - ((it_w + 28'd1) << 1);
    tail     = cn + q;

    // The valid bit is cleared while reset is held.
    s2_next.valid     = s1.valid && !rst;
    s2_next.idx_valid = s1.idx_valid;
    s2_next.kind      = s1.kind;

    case (s1.region)
      pseo_pkg::REGION_CIRCLE: begin
        s2_next.s_off = 28'(s1.p_circ) + it_w;
        s2_next.e_off = base;
      end
      pseo_pkg::REGION_RADIAL: begin
        s2_next.s_off = tail - lr_m2 + ir_w - nc_w;
        s2_next.e_off = base + seven_it;
      end
      pseo_pkg::REGION_ZERO: begin
        s2_next.s_off = '0;
        s2_next.e_off = s1.dir ? it_w : seven_it;
      end
      pseo_pkg::REGION_ONE: begin
        s2_next.s_off = '0;
        s2_next.e_off = s1.dir ? (nt_w + (it_w << 2) + (it_w << 1))
                               : (seven_nt + (it_w << 3) + it_w);
      end
      pseo_pkg::REGION_NEXT_OUTER: begin
        s2_next.s_off = tail;
        s2_next.e_off = base + seven_it;
      end
      pseo_pkg::REGION_OUTER: begin
        s2_next.s_off = tail;
        s2_next.e_off = base + seven_it + 28'd6;
      end
      default: begin
        s2_next.s_off = '0;
        s2_next.e_off = '0;
      end
    endcase

    // Total: nine per interior circle plus 14 or 23 per angle.
    s2_next.s_tot = 28'(s1.p_nr) - (nt_w << 2);
    s2_next.e_tot = s1.dir ? ((nt_w << 4) - (nt_w << 1))
                           : ((nt_w << 4) + seven_nt);
  end

  // Stage register; the valid bit is cleared through its next value.
  always_ff @(posedge clk) begin
    s2 <= s2_next;
  end

endmodule

`default_nettype wire

// File: rtl/pseo_out.sv
// Third pipeline stage: final scale-and-add and the result register.
`default_nettype none

module pseo_out (
  input  logic           clk,
  input  logic           rst,
  input  pseo_pkg::s2_t  s2,
  output logic           done,
  output pseo_pkg::rsp_t rsp
);

  pseo_pkg::rsp_t rsp_next;

  // Each result is nine times its first term plus its second.
  always_comb begin
    rsp_next.entry_offset   = s2.idx_valid ? ((s2.s_off << 3) + s2.s_off + s2.e_off) : '0;
    rsp_next.stencil_kind   = s2.kind;
    rsp_next.total_nonzeros = (s2.s_tot << 3) + s2.s_tot + s2.e_tot;
    rsp_next.index_valid    = s2.idx_valid;
  end

  // Result register and its strobe.
  always_ff @(posedge clk) begin
    rsp <= rsp_next;
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= s2.valid;
    end
  end

endmodule

`default_nettype wire

// File: rtl/polar_stencil_entry_offset_top.sv
// Top level of the polar stencil entry offset block.
//
// A request beat carries a grid node (radial and angular index) and is taken
// at any rising edge where start is high and busy is low; busy never rises,
// so one request may be issued every cycle.
// The result beat (row start offset, stencil class, total nonzero count and
// an in-grid flag) appears on rsp with done high for exactly one cycle.
// Done follows the accepting edge through the three register stages
// (product stage, sum stage, result register). Throughput is one beat
// per cycle.
// The receiver cannot stall; results leave in request order.
// Configuration is written through cfg_write, cfg_index and cfg_data and
// takes effect at the next edge; write it only while no beat is in flight.
// Reset clears the pipeline valid bits and the strobe and loads the
// configuration defaults (4 circles, 1 angle, region sizes 2, across-origin
// inner boundary).
`default_nettype none

module polar_stencil_entry_offset_top #(
  parameter int RADIAL_MAX  = pseo_pkg::RADIAL_MAX_DEFAULT,
  parameter int ANGULAR_MAX = pseo_pkg::ANGULAR_MAX_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  pseo_pkg::req_t                    req,
  output logic                              done,
  output pseo_pkg::rsp_t                    rsp,
  input  logic                              cfg_write,
  input  logic [pseo_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pseo_pkg::CFG_DATA_W-1:0]   cfg_data
);

  `include "polar_stencil_entry_offset_top_assert.svh"

  pseo_pkg::cfg_t cfg;
  pseo_pkg::s1_t  s1;
  pseo_pkg::s2_t  s2;
  logic           accept;

  // The pipeline never holds off a request.
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.radial_count         <= 13'd4;
      cfg.angular_count        <= 13'd1;
      cfg.circle_region_count  <= 12'd2;
      cfg.radial_region_length <= 12'd2;
      cfg.dirichlet_inner      <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        pseo_pkg::CFG_RADIAL_COUNT:  cfg.radial_count         <= cfg_data;
        pseo_pkg::CFG_ANGULAR_COUNT: cfg.angular_count        <= cfg_data;
        pseo_pkg::CFG_CIRCLE_REGION: cfg.circle_region_count  <= cfg_data[11:0];
        pseo_pkg::CFG_RADIAL_REGION: cfg.radial_region_length <= cfg_data[11:0];
        pseo_pkg::CFG_DIRICHLET:     cfg.dirichlet_inner      <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // Pipeline stages.
  pseo_prod #(
    .RADIAL_MAX (RADIAL_MAX),
    .ANGULAR_MAX(ANGULAR_MAX)
  ) u_prod (
    .clk     (clk),
    .rst     (rst),
    .in_valid(accept),
    .req     (req),
    .cfg     (cfg),
    .s1      (s1)
  );

  pseo_sum u_sum (
    .clk(clk),
    .rst(rst),
    .s1 (s1),
    .s2 (s2)
  );

  pseo_out u_out (
    .clk (clk),
    .rst (rst),
    .s2  (s2),
    .done(done),
    .rsp (rsp)
  );

  // Every accepted beat yields a result through the three register stages.
  `PSEO_ASSERT_DLY3(a_latency, accept, done, "result beat missing after request")
  // A result beat is never produced without an earlier request.
  `PSEO_ASSERT_IMP(a_no_extra, done, $past(accept, 3), "result beat without request")
  // Nodes outside the grid report zero offset and interior class.
  `PSEO_ASSERT_IMP(a_invalid_zero, done && !rsp.index_valid, (rsp.entry_offset == '0) && (rsp.stencil_kind == pseo_pkg::KIND_INTERIOR), "invalid node with nonzero fields")
  // The across-origin class only occurs with a non-Dirichlet inner boundary.
  `PSEO_ASSERT_IMP(a_across_mode, done && (rsp.stencil_kind == pseo_pkg::KIND_ACROSS), !cfg.dirichlet_inner, "across-origin class in Dirichlet mode")

endmodule

`default_nettype wire
